@@ rtl/ualu_pkg.sv @@
// Shared definitions for the unsigned ALU: operation and error codes and the
// control word that travels down the pipeline. No dependencies.
package ualu_pkg;

  localparam int unsigned DefaultDataWidth = 32;
  localparam int unsigned OpWidth          = 4;

  localparam logic [OpWidth-1:0] OP_CMP = 4'd0;
  localparam logic [OpWidth-1:0] OP_ADD = 4'd1;
  localparam logic [OpWidth-1:0] OP_SUB = 4'd2;
  localparam logic [OpWidth-1:0] OP_MUL = 4'd3;
  localparam logic [OpWidth-1:0] OP_DIV = 4'd4;
  localparam logic [OpWidth-1:0] OP_MOD = 4'd5;
  localparam logic [OpWidth-1:0] OP_AND = 4'd6;
  localparam logic [OpWidth-1:0] OP_OR  = 4'd7;
  localparam logic [OpWidth-1:0] OP_XOR = 4'd8;
  localparam logic [OpWidth-1:0] OP_NOT = 4'd9;
  localparam logic [OpWidth-1:0] OP_SHL = 4'd10;
  localparam logic [OpWidth-1:0] OP_SHR = 4'd11;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TYPE     = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

  localparam logic [1:0] CMP_EQ = 2'b00;
  localparam logic [1:0] CMP_GT = 2'b01;
  localparam logic [1:0] CMP_LT = 2'b11;

  // Control word carried alongside the datapath of every stage.
  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic [1:0]         err;
    logic [1:0]         cmp;
    logic               zero_out;  // force result_value to zero
  } ctl_t;

endpackage

@@ rtl/ualu_front.sv @@
// First pipeline stage: decodes the request, checks operand type and the
// divisor, and computes the results that need no multiplier or divider. Depends on ualu_pkg.
module ualu_front import ualu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [OpWidth-1:0]    in_op,
  input  logic [DATA_WIDTH-1:0] in_a,
  input  logic [DATA_WIDTH-1:0] in_b,
  input  logic                  in_type_ok,
  output logic                  out_valid,
  output ctl_t                  out_ctl,
  output logic [DATA_WIDTH-1:0] out_a,
  output logic [DATA_WIDTH-1:0] out_b,
  output logic [DATA_WIDTH-1:0] out_simple
);

  localparam logic [DATA_WIDTH-1:0] WidthVal = DATA_WIDTH'(DATA_WIDTH);

  ctl_t                  ctl_next;
  logic [DATA_WIDTH-1:0] simple_next;
  logic                  big_shift;

  always_comb begin
    ctl_next          = '0;
    ctl_next.op       = in_op;
    ctl_next.err      = ERR_NONE;
    ctl_next.cmp      = CMP_EQ;
    ctl_next.zero_out = 1'b0;
    simple_next       = '0;
    big_shift         = (in_b >= WidthVal);
    if (in_op == OP_NOT) begin
      simple_next = ~in_a;
    end else if (in_op > OP_SHR) begin
      ctl_next.zero_out = 1'b1;
    end else if (!in_type_ok) begin
      ctl_next.err      = ERR_TYPE;
      ctl_next.zero_out = 1'b1;
    end else begin
      case (in_op)
        OP_CMP: begin
          ctl_next.zero_out = 1'b1;
          if (in_a == in_b) ctl_next.cmp = CMP_EQ;
          else if (in_a > in_b) ctl_next.cmp = CMP_GT;
          else ctl_next.cmp = CMP_LT;
        end
        OP_ADD: simple_next = in_a + in_b;
        OP_SUB: simple_next = in_a - in_b;
        OP_DIV, OP_MOD: begin
          if (in_b == '0) begin
            ctl_next.err      = ERR_DIV_ZERO;
            ctl_next.zero_out = 1'b1;
          end
        end
        OP_AND: simple_next = in_a & in_b;
        OP_OR:  simple_next = in_a | in_b;
        OP_XOR: simple_next = in_a ^ in_b;
        OP_SHL: simple_next = big_shift ? '0 : (in_a << in_b);
        OP_SHR: simple_next = big_shift ? '0 : (in_a >> in_b);
        default: simple_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl    <= ctl_next;
      out_a      <= in_a;
      out_b      <= in_b;
      out_simple <= simple_next;
    end
  end

endmodule

@@ rtl/ualu_stage.sv @@
// One arithmetic pipeline stage: one restoring-division bit and, in the
// first stages, one byte of the multiplier. Depends on ualu_pkg.
module ualu_stage import ualu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefaultDataWidth,
  parameter int unsigned STAGE      = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  ctl_t                  in_ctl,
  input  logic [DATA_WIDTH-1:0] in_a,
  input  logic [DATA_WIDTH-1:0] in_b,
  input  logic [DATA_WIDTH-1:0] in_simple,
  input  logic [DATA_WIDTH-1:0] in_quo,
  input  logic [DATA_WIDTH-1:0] in_rem,
  input  logic [DATA_WIDTH-1:0] in_prod,
  output logic                  out_valid,
  output ctl_t                  out_ctl,
  output logic [DATA_WIDTH-1:0] out_a,
  output logic [DATA_WIDTH-1:0] out_b,
  output logic [DATA_WIDTH-1:0] out_simple,
  output logic [DATA_WIDTH-1:0] out_quo,
  output logic [DATA_WIDTH-1:0] out_rem,
  output logic [DATA_WIDTH-1:0] out_prod
);

  localparam int unsigned Chunks = (DATA_WIDTH + 7) / 8;
  localparam int unsigned ExtW   = Chunks * 8;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] quo_next;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] prod_next;
  logic [ExtW-1:0]       b_ext;
  logic [7:0]            b_byte;
  logic [DATA_WIDTH-1:0] partial;

  always_comb begin
    trial = {in_rem, in_quo[DATA_WIDTH-1]};
    diff  = trial - {1'b0, in_b};
    if (trial >= {1'b0, in_b}) begin
      rem_next = diff[DATA_WIDTH-1:0];
      quo_next = {in_quo[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_next = trial[DATA_WIDTH-1:0];
      quo_next = {in_quo[DATA_WIDTH-2:0], 1'b0};
    end
  end

  generate
    if (STAGE < Chunks) begin : g_mul
      always_comb begin
        b_ext     = ExtW'(in_b);
        b_byte    = b_ext[8*STAGE +: 8];
        partial   = DATA_WIDTH'(in_a * DATA_WIDTH'(b_byte));
        prod_next = in_prod + (partial << (8 * STAGE));
      end
    end else begin : g_nomul
      always_comb begin
        b_ext     = '0;
        b_byte    = '0;
        partial   = '0;
        prod_next = in_prod;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl    <= in_ctl;
      out_a      <= in_a;
      out_b      <= in_b;
      out_simple <= in_simple;
      out_quo    <= quo_next;
      out_rem    <= rem_next;
      out_prod   <= prod_next;
    end
  end

endmodule

@@ rtl/unsigned_alu_32bit_top.sv @@
// Top level of the pipelined unsigned ALU. Instantiates ualu_front and one
// ualu_stage per result bit; depends on ualu_pkg.
//
// Every request passes through the same pipeline of DATA_WIDTH + 2 register
// stages: a decode stage, DATA_WIDTH division stages (one quotient bit each,
// with the multiplier folded in a byte at a time over the first stages) and an
// output register. A new request is taken every cycle while the pipeline
// advances, and results leave in the order the requests came, whatever the
// operation. The whole pipeline moves as one: it advances whenever the output
// register is empty or is being read, so holding m_axis_tready low freezes
// every stage and nothing is lost or repeated. Codes 12 to 15 return all zeros;
// a type mismatch (but for NOT and codes 12 to 15) or a zero divisor zeroes
// the value and sets error_code; shift counts of DATA_WIDTH or more give zero.
module unsigned_alu_32bit_top import ualu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation [3:0], operand_a, operand_b, zero padding to whole bytes
  input  logic [((2*DATA_WIDTH+OpWidth+7)/8)*8-1:0] s_axis_tdata,
  // b_is_uint32
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // result_value, compare_result (2), error_code (2), zero padding
  output logic [((DATA_WIDTH+4+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OutW = ((DATA_WIDTH + 4 + 7) / 8) * 8;

  logic adv;

  logic                  v   [DATA_WIDTH+1];
  ctl_t                  c   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] a   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] b   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] s   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] q   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] r   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] p   [DATA_WIDTH+1];

  logic [DATA_WIDTH-1:0] result_next;
  logic [DATA_WIDTH-1:0] result_value;
  logic [1:0]            compare_result;
  logic [1:0]            error_code;

  // The pipeline advances as a whole when the output slot can take a result.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  ualu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (s_axis_tvalid),
    .in_op      (s_axis_tdata[OpWidth-1:0]),
    .in_a       (s_axis_tdata[OpWidth +: DATA_WIDTH]),
    .in_b       (s_axis_tdata[OpWidth+DATA_WIDTH +: DATA_WIDTH]),
    .in_type_ok (s_axis_tuser),
    .out_valid  (v[0]),
    .out_ctl    (c[0]),
    .out_a      (a[0]),
    .out_b      (b[0]),
    .out_simple (s[0])
  );

  // The dividend starts as operand_a, the remainder and product at zero.
  assign q[0] = a[0];
  assign r[0] = '0;
  assign p[0] = '0;

  generate
    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
      ualu_stage #(.DATA_WIDTH(DATA_WIDTH), .STAGE(i)) u_stage (
        .clk        (clk),
        .rst        (rst),
        .adv        (adv),
        .in_valid   (v[i]),
        .in_ctl     (c[i]),
        .in_a       (a[i]),
        .in_b       (b[i]),
        .in_simple  (s[i]),
        .in_quo     (q[i]),
        .in_rem     (r[i]),
        .in_prod    (p[i]),
        .out_valid  (v[i+1]),
        .out_ctl    (c[i+1]),
        .out_a      (a[i+1]),
        .out_b      (b[i+1]),
        .out_simple (s[i+1]),
        .out_quo    (q[i+1]),
        .out_rem    (r[i+1]),
        .out_prod   (p[i+1])
      );
    end
  endgenerate

  // Pick the finished value for the operation; errors and compare read zero.
  always_comb begin
    if (c[DATA_WIDTH].zero_out) begin
      result_next = '0;
    end else begin
      case (c[DATA_WIDTH].op)
        OP_MUL:  result_next = p[DATA_WIDTH];
        OP_DIV:  result_next = q[DATA_WIDTH];
        OP_MOD:  result_next = r[DATA_WIDTH];
        default: result_next = s[DATA_WIDTH];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= v[DATA_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value   <= result_next;
      compare_result <= c[DATA_WIDTH].cmp;
      error_code     <= c[DATA_WIDTH].err;
    end
  end

  assign m_axis_tdata = OutW'({error_code, compare_result, result_value});

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the pipelined unsigned ALU top level.
// Drives operation requests over the input stream, predicts each result and
// compares it with the output stream; depends on ualu_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ualu_pkg::*;

  localparam int unsigned DW      = 32;
  localparam int unsigned IN_W    = ((2*DW+OpWidth+7)/8)*8;
  localparam int unsigned OUT_W   = ((DW+4+7)/8)*8;
  localparam int unsigned LATENCY = DW + 2;

  // One operation request as it enters the block.
  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic [DW-1:0]      a;
    logic [DW-1:0]      b;
    logic               b_uint;
  } alu_req_t;

  // One answer as it leaves the block.
  typedef struct packed {
    logic [DW-1:0] value;
    logic [1:0]    cmp;
    logic [1:0]    err;
  } alu_rsp_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  alu_req_t pending_reqs[$];
  alu_rsp_t expected_rsps[$];
  int unsigned error_count;
  // Randomly idling is switched off on both sides during the quiet window.
  bit quiet_window;
  // Countdown for the long hold-off of the receiver.
  int unsigned holdoff_cycles;

  unsigned_alu_32bit_top #(.DATA_WIDTH(DW)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the answer the block must give for one request.
  function automatic alu_rsp_t alu_predict(alu_req_t req);
    alu_rsp_t rsp;
    rsp = '0;
    if (req.op == OP_NOT) begin
      rsp.value = ~req.a;
    end else if (req.op > OP_SHR) begin
      // Unused codes answer all zeros.
    end else if (!req.b_uint) begin
      rsp.err = ERR_TYPE;
    end else begin
      case (req.op)
        OP_CMP: begin
          rsp.cmp = (req.a == req.b) ? CMP_EQ : ((req.a > req.b) ? CMP_GT : CMP_LT);
        end
        OP_ADD: rsp.value = req.a + req.b;
        OP_SUB: rsp.value = req.a - req.b;
        OP_MUL: rsp.value = req.a * req.b;
        OP_DIV: begin
          if (req.b == 0) rsp.err = ERR_DIV_ZERO;
          else rsp.value = req.a / req.b;
        end
        OP_MOD: begin
          if (req.b == 0) rsp.err = ERR_DIV_ZERO;
          else rsp.value = req.a % req.b;
        end
        OP_AND: rsp.value = req.a & req.b;
        OP_OR:  rsp.value = req.a | req.b;
        OP_XOR: rsp.value = req.a ^ req.b;
        OP_SHL: rsp.value = (req.b >= DW) ? '0 : (req.a << req.b);
        default: rsp.value = (req.b >= DW) ? '0 : (req.a >> req.b);
      endcase
    end
    return rsp;
  endfunction

  // Picks an operand biased toward the edges of its range.
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DW'($urandom_range(0, 40));
      3: return {1'b1, {(DW-1){1'b0}}};
      default: return $urandom();
    endcase
  endfunction

  function automatic alu_req_t make_req(logic [OpWidth-1:0] op, logic [DW-1:0] a,
                                        logic [DW-1:0] b, logic b_uint);
    alu_req_t req;
    req.op = op;
    req.a = a;
    req.b = b;
    req.b_uint = b_uint;
    return req;
  endfunction

  // Stimulus: a directed set covering every operation and each special case,
  // then random requests. The driver below consumes the queue.
  initial begin
    alu_req_t req;
    logic [DW-1:0] b_val;
    for (int op = 0; op <= OP_SHR; op++) begin
      pending_reqs.push_back(make_req(OpWidth'(op), '1, '1, 1'b1));
    end
    pending_reqs.push_back(make_req(OP_CMP, 32'd5, 32'd9, 1'b1));
    pending_reqs.push_back(make_req(OP_CMP, 32'd5, 32'd5, 1'b1));
    pending_reqs.push_back(make_req(OP_ADD, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_DIV, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_DIV, 32'd77, '0, 1'b1));
    pending_reqs.push_back(make_req(OP_MOD, 32'd77, '0, 1'b1));
    pending_reqs.push_back(make_req(OP_NOT, '0, 32'h1234_5678, 1'b0));
    pending_reqs.push_back(make_req(OP_SHL, '1, 32'd31, 1'b1));
    pending_reqs.push_back(make_req(OP_SHL, '1, 32'd32, 1'b1));
    pending_reqs.push_back(make_req(OP_SHR, '1, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(make_req(4'd12, '1, '1, 1'b1));
    pending_reqs.push_back(make_req(4'd15, '1, '1, 1'b0));
    pending_reqs.push_back(make_req(OP_MUL, '1, '1, 1'b1));
    for (int n = 0; n < 1030; n++) begin
      b_val = pick_operand();
      req.op = ($urandom_range(0, 19) == 0) ? OpWidth'($urandom_range(12, 15))
                                            : OpWidth'($urandom_range(0, 11));
      req.a = pick_operand();
      // Shift counts mostly in range so that the shifter itself is exercised.
      if ((req.op == OP_SHL || req.op == OP_SHR) && $urandom_range(0, 3) != 0) begin
        b_val = DW'($urandom_range(0, DW - 1));
      end
      req.b = b_val;
      req.b_uint = ($urandom_range(0, 9) != 0);
      pending_reqs.push_back(req);
    end
  end

  // Quiet window without random idling, then one long receiver hold-off
  // while the sender keeps offering requests so the pipeline fills.
  initial begin
    quiet_window = 1'b0;
    holdoff_cycles = 0;
    wait (!rst);
    repeat (200) @(posedge clk);
    quiet_window = 1'b1;
    repeat (150) @(posedge clk);
    quiet_window = 1'b0;
    repeat (100) @(posedge clk);
    holdoff_cycles = 3 * LATENCY;
    while (holdoff_cycles != 0) begin
      @(posedge clk);
      holdoff_cycles = holdoff_cycles - 1;
    end
  end

  // Driver: presents the head of the queue, holding it until accepted.
  always @(posedge clk) begin
    alu_req_t head;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(alu_predict(pending_reqs.pop_front()));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_reqs.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 9)) begin
          head = pending_reqs[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_W'({head.b, head.a, head.op});
          s_axis_tuser <= head.b_uint;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    alu_rsp_t got;
    alu_rsp_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[DW-1:0];
        got.cmp = m_axis_tdata[DW+1:DW];
        got.err = m_axis_tdata[DW+3:DW+2];
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: result_value expected %h actual %h", $time, want.value, got.value);
            error_count++;
          end
          if (got.cmp !== want.cmp) begin
            $display("%0t: compare_result expected %b actual %b", $time, want.cmp, got.cmp);
            error_count++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error_code expected %0d actual %0d", $time, want.err, got.err);
            error_count++;
          end
        end
      end
      m_axis_tready <= (holdoff_cycles == 0) && (quiet_window || $urandom_range(0, 99) >= 9);
    end
  end

  // Reset, then wait for all requests and results before judging the run.
  initial begin
    error_count = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (pending_reqs.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

endmodule
